[rtl/core/ocbu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocbu_pkg
// Shared constants and pipeline types for the occupancy cell Bayes update unit.
// ----------------------------------------------------------------------------
package ocbu_pkg;

    localparam int unsigned CELLS_DEF  = 65536;
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned PROB_W     = 17;
    localparam int unsigned BELIEF_W   = 8;
    localparam int unsigned PROD_W     = 25;
    localparam int unsigned REM_W      = 32;
    localparam int unsigned DIV_STAGES = BELIEF_W;

    localparam logic [PROB_W-1:0]   PROB_ONE     = PROB_W'(65536);
    localparam logic [BELIEF_W-1:0] BELIEF_ONE   = BELIEF_W'(255);
    localparam logic [BELIEF_W-1:0] BELIEF_RESET = BELIEF_W'(127);
    localparam logic [BELIEF_W-1:0] FLOOR_RESET  = BELIEF_W'(20);

    typedef struct packed {
        logic                valid;
        logic                inrange;
        logic [IDX_W-1:0]    idx;
        logic [PROB_W-1:0]   prob;
    } hold_t;

    typedef struct packed {
        logic                valid;
        logic                inrange;
        logic [IDX_W-1:0]    idx;
        logic [BELIEF_W-1:0] b;
        logic [PROD_W-1:0]   pb;
        logic [PROD_W-1:0]   qb;
    } mul_t;

    typedef struct packed {
        logic                valid;
        logic                inrange;
        logic                zero;
        logic [IDX_W-1:0]    idx;
        logic [BELIEF_W-1:0] b;
        logic [PROD_W-1:0]   den;
        logic [REM_W-1:0]    rem;
        logic [BELIEF_W-1:0] q;
    } div_t;

endpackage

[rtl/core/occupancy_cell_bayes_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_cell_bayes_update_unit
// Binary Bayes update of a byte occupancy grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// Takes one request per cycle (start while busy is low) and returns the new
// cell byte with a done strobe; done cannot be held off, so the receiver
// must take every result in the cycle it appears. Requests retire in order.
// The grid lives in one RAM with a single read and a single write port; the
// update runs through a multiply stage and an 8-stage restoring divider
// before write-back. A request for a cell that is still in flight waits in
// the input register until the earlier write lands, with busy high. After
// reset busy stays high while the grid is swept to 127. An index at or
// beyond CELLS returns 0 and leaves the grid alone. floor_level is written
// over cfg_data, always ready.
// ----------------------------------------------------------------------------
module occupancy_cell_bayes_update_unit
    import ocbu_pkg::*;
#(
    parameter int unsigned CELLS = CELLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [IDX_W-1:0]    cell_index,
    input  logic [PROB_W-1:0]   meas_prob,
    output logic                done,
    output logic [IDX_W-1:0]    cell_echo,
    output logic [BELIEF_W-1:0] new_belief,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BELIEF_W-1:0] cfg_data
);

    localparam int unsigned ADDR_W = $clog2(CELLS);

    logic [BELIEF_W-1:0] floor_reg;
    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;

    hold_t hold_reg, hold_next;
    hold_t a_reg, a_next;
    mul_t  m_reg, m_next;
    div_t  div_reg  [0:DIV_STAGES];
    div_t  div_next [0:DIV_STAGES];
    div_t  fin;

    logic                done_reg;
    logic [IDX_W-1:0]    cell_echo_reg;
    logic [BELIEF_W-1:0] new_belief_reg;

    logic                hazard;
    logic                issue;
    logic                accept;
    logic [PROB_W-1:0]   prob_sat;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BELIEF_W-1:0] ram_wdata;
    logic [BELIEF_W-1:0] ram_rdata;

    logic [PROD_W-1:0]   den;
    logic [BELIEF_W-1:0] floored;
    logic [BELIEF_W-1:0] new_val;
    logic                wr_cell;

    ocbu_ram #(
        .WIDTH (BELIEF_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ADDR_W'(hold_reg.idx)),
        .rdata (ram_rdata)
    );

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            floor_reg <= cfg_data;
        end
    end

    // grid clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(CELLS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // same-cell interlock against every stage up to write-back
    always_comb
    begin
        hazard = (a_reg.valid && a_reg.idx == hold_reg.idx)
              || (m_reg.valid && m_reg.idx == hold_reg.idx);
        for (int i = 0; i <= DIV_STAGES; i++)
        begin
            hazard = hazard || (div_reg[i].valid && div_reg[i].idx == hold_reg.idx);
        end
    end

    assign issue    = hold_reg.valid && !hazard && !clearing_reg;
    assign busy     = clearing_reg || (hold_reg.valid && hazard);
    assign accept   = start && !busy;
    assign prob_sat = (meas_prob > PROB_ONE) ? PROB_ONE : meas_prob;

    always_comb
    begin
        hold_next = hold_reg;
        if (accept)
        begin
            hold_next.valid   = 1'b1;
            hold_next.inrange = (32'(cell_index) < 32'(CELLS));
            hold_next.idx     = cell_index;
            hold_next.prob    = prob_sat;
        end
        else if (issue)
        begin
            hold_next.valid = 1'b0;
        end
        a_next       = hold_reg;
        a_next.valid = issue;
    end

    // multiply stage: RAM data arrives here
    always_comb
    begin
        m_next.valid   = a_reg.valid;
        m_next.inrange = a_reg.inrange;
        m_next.idx     = a_reg.idx;
        m_next.b       = ram_rdata;
        m_next.pb      = {8'd0, a_reg.prob} * {17'd0, ram_rdata};
        m_next.qb      = {8'd0, PROB_ONE - a_reg.prob} * {17'd0, BELIEF_ONE - ram_rdata};
    end

    // denominator and 255 * numerator
    always_comb
    begin
        den                = m_reg.pb + m_reg.qb;
        div_next[0].valid   = m_reg.valid;
        div_next[0].inrange = m_reg.inrange;
        div_next[0].zero    = (den == '0);
        div_next[0].idx     = m_reg.idx;
        div_next[0].b       = m_reg.b;
        div_next[0].den     = den;
        div_next[0].rem     = REM_W'({m_reg.pb, 8'd0}) - REM_W'(m_reg.pb);
        div_next[0].q       = '0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        localparam int unsigned K = DIV_STAGES - 1 - j;
        logic [REM_W-1:0] sh;

        assign sh = REM_W'(div_reg[j].den) << K;

        always_comb
        begin
            div_next[j+1] = div_reg[j];
            if (div_reg[j].rem >= sh)
            begin
                div_next[j+1].rem  = div_reg[j].rem - sh;
                div_next[j+1].q[K] = 1'b1;
            end
        end
    end

    // write-back and result
    assign fin     = div_reg[DIV_STAGES];
    assign floored = (fin.q < floor_reg) ? floor_reg : fin.q;
    assign new_val = fin.zero ? fin.b : floored;
    assign wr_cell = fin.valid && fin.inrange && !fin.zero;

    assign ram_we    = clearing_reg || wr_cell;
    assign ram_waddr = clearing_reg ? clr_addr_reg : ADDR_W'(fin.idx);
    assign ram_wdata = clearing_reg ? BELIEF_RESET : new_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg.valid <= 1'b0;
            a_reg.valid    <= 1'b0;
            m_reg.valid    <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_reg[i].valid <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
            a_reg    <= a_next;
            m_reg    <= m_next;
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                div_reg[i] <= div_next[i];
            end
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_echo_reg  <= fin.idx;
        new_belief_reg <= fin.inrange ? new_val : '0;
    end

    assign done       = done_reg;
    assign cell_echo  = cell_echo_reg;
    assign new_belief = new_belief_reg;

endmodule

[rtl/core/ocbu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocbu_ram
// Simple dual-port RAM, one write port, one registered read port (read-first).
// ----------------------------------------------------------------------------
module ocbu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ocbu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocbu_checker
// Port-level checks for the occupancy cell Bayes update unit, bound to it.
// ----------------------------------------------------------------------------
module ocbu_checker
    import ocbu_pkg::*;
#(
    parameter int unsigned CELLS = CELLS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic [IDX_W-1:0]    cell_index,
    input logic [PROB_W-1:0]   meas_prob,
    input logic                done,
    input logic [IDX_W-1:0]    cell_echo,
    input logic [BELIEF_W-1:0] new_belief,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [BELIEF_W-1:0] cfg_data
);

    logic [BELIEF_W-1:0] floor_shadow_reg;
    logic                swept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_shadow_reg <= FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            floor_shadow_reg <= cfg_data;
        end
    end

    // set once busy first drops after reset, i.e. the sweep is over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swept_reg <= 1'b0;
        end
        else if (!busy)
        begin
            swept_reg <= 1'b1;
        end
    end

    // grid sweep holds off requests right after reset
    a_busy_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> busy)
        else $error("busy low right after reset");

    // out-of-grid request reports zero
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && 32'(cell_echo) >= 32'(CELLS)) |-> (new_belief == '0))
        else $error("out-of-grid result not zero");

    // below the floor only for an untouched empty cell
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && 32'(cell_echo) < 32'(CELLS) && new_belief < floor_shadow_reg)
            |-> (new_belief == '0))
        else $error("result below floor");

    // no result while the grid is still being swept
    a_no_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !swept_reg |-> !done)
        else $error("result during sweep");

endmodule

bind occupancy_cell_bayes_update_unit ocbu_checker #(.CELLS(CELLS)) u_ocbu_checker (.*);

[tb/tb_occupancy_cell_bayes_update_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_cell_bayes_update_unit
// Self-checking bench for the occupancy cell Bayes update unit.
// ----------------------------------------------------------------------------
// Keeps its own copy of the belief grid and floor level, predicts the new
// byte of every accepted request and checks each done strobe against the
// oldest prediction. Directed requests cover probability and belief
// extremes, saturation above one, zero denominators and the floor at 0, 20
// and 255. The random stream then updates a small pool of cells heavily,
// with back-to-back same-cell requests, random gaps and quiet periods
// between floor changes.
// ----------------------------------------------------------------------------
module tb_occupancy_cell_bayes_update_unit;
    import ocbu_pkg::*;

    localparam int unsigned LATENCY = 12;
    localparam int unsigned PHASE_REQS = 225;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [BELIEF_W-1:0] belief;
    } cell_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [IDX_W-1:0]    cell_index = '0;
    logic [PROB_W-1:0]   meas_prob = '0;
    logic                done;
    logic [IDX_W-1:0]    cell_echo;
    logic [BELIEF_W-1:0] new_belief;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [BELIEF_W-1:0] cfg_data = '0;

    logic [BELIEF_W-1:0] belief_map [CELLS_DEF];
    logic [BELIEF_W-1:0] floor_now;
    cell_result_t        pending_beliefs [$];
    int                  errors = 0;
    bit                  burst_mode = 1'b0;

    always #4 clk = ~clk;

    occupancy_cell_bayes_update_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cell_index (cell_index),
        .meas_prob  (meas_prob),
        .done       (done),
        .cell_echo  (cell_echo),
        .new_belief (new_belief),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // binary Bayes rule on the local grid; zero denominator keeps the cell
    function automatic logic [BELIEF_W-1:0] bayes_update(input logic [IDX_W-1:0] cell_id,
                                                         input logic [PROB_W-1:0] prob);
        longint unsigned p;
        longint unsigned b;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        p = (prob > PROB_ONE) ? 64'd65536 : 64'(prob);
        b = 64'(belief_map[cell_id]);
        num = p * b;
        den = (64'd65536 - p) * (64'd255 - b) + num;
        if (den == 0)
            return belief_map[cell_id];
        q = (64'd255 * num) / den;
        if (q > 64'd255)
            q = 64'd255;
        if (q < 64'(floor_now))
            q = 64'(floor_now);
        belief_map[cell_id] = q[BELIEF_W-1:0];
        return q[BELIEF_W-1:0];
    endfunction

    task automatic send_request(input logic [IDX_W-1:0] cell_id,
                                input logic [PROB_W-1:0] prob);
        int gap;
        cell_result_t exp_r;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        cell_index <= cell_id;
        meas_prob  <= prob;
        @(posedge clk);
        while (busy) @(posedge clk);
        exp_r.idx    = cell_id;
        exp_r.belief = bayes_update(cell_id, prob);
        pending_beliefs = {pending_beliefs, exp_r};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_beliefs.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_floor(input logic [BELIEF_W-1:0] level);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        floor_now = level;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PROB_ONE;
            2: return PROB_W'($urandom_range(65537, 131071));
            3: return PROB_W'($urandom_range(0, 255));
            4: return PROB_W'($urandom_range(65280, 65536));
            5: return PROB_W'($urandom_range(32000, 33536));
            default: return PROB_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_cell(input logic [IDX_W-1:0] last_cell);
        case ($urandom_range(0, 9)) inside
            [0:4]: return IDX_W'($urandom_range(0, 15));
            [5:6]: return last_cell;
            7: return IDX_W'($urandom_range(0, 65535));
            8: return IDX_W'(65535 - $urandom_range(0, 3));
            default: return IDX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // reset floor; probability extremes, saturation, zero denominators
    task automatic test_default_floor();
        burst_mode = 1'b1;
        send_request(16'd0, 17'd0);
        send_request(16'd0, PROB_ONE);
        send_request(16'd0, 17'd0);
        send_request(16'hFFFF, PROB_ONE);
        send_request(16'hFFFF, 17'd0);
        send_request(16'hFFFF, 17'h1FFFF);
        send_request(16'd1, 17'd32768);
        send_request(16'd2, 17'd1);
        send_request(16'd3, 17'd65535);
        send_request(16'd4, 17'd65537);
        send_request(16'd5, 17'd0);
        send_request(16'd5, 17'd1);
        send_request(16'h5555, 17'h0AAAA);
        send_request(16'hAAAA, 17'h15555);
        send_request(16'd6, 17'd40000);
        send_request(16'd6, 17'd40000);
        send_request(16'd6, 17'd40000);
        burst_mode = 1'b0;
        wait_drained();
    endtask

    task automatic test_floor_zero();
        write_floor(8'd0);
        send_request(16'd10, 17'd0);
        send_request(16'd10, PROB_ONE);
        send_request(16'd10, 17'd65535);
        send_request(16'd11, 17'd1);
        wait_drained();
    endtask

    task automatic test_floor_max();
        write_floor(8'd255);
        send_request(16'd12, 17'd32768);
        send_request(16'd12, 17'd0);
        send_request(16'd13, 17'd0);
        wait_drained();
    endtask

    task automatic test_random_stream();
        logic [BELIEF_W-1:0] levels [6];
        logic [IDX_W-1:0]    last_cell;
        levels[0] = BELIEF_W'($urandom_range(1, 254));
        levels[1] = 8'd0;
        levels[2] = 8'd255;
        levels[3] = FLOOR_RESET;
        levels[4] = BELIEF_W'($urandom_range(0, 255));
        levels[5] = BELIEF_W'($urandom_range(0, 255));
        last_cell = '0;
        foreach (levels[k])
        begin
            write_floor(levels[k]);
            repeat (PHASE_REQS)
            begin
                if ($urandom_range(0, 39) == 0)
                    burst_mode = ~burst_mode;
                last_cell = pick_cell(last_cell);
                send_request(last_cell, pick_prob());
            end
            burst_mode = 1'b0;
            wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        cell_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_beliefs.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending, cell %0d belief %0d",
                         $time, cell_echo, new_belief);
            end
            else
            begin
                exp_r = pending_beliefs.pop_front();
                if (cell_echo !== exp_r.idx)
                begin
                    errors++;
                    $display("%0t: cell_echo expected %0d actual %0d",
                             $time, exp_r.idx, cell_echo);
                end
                if (new_belief !== exp_r.belief)
                begin
                    errors++;
                    $display("%0t: new_belief cell %0d expected %0d actual %0d",
                             $time, exp_r.idx, exp_r.belief, new_belief);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        foreach (belief_map[i])
            belief_map[i] = BELIEF_RESET;
        floor_now = FLOOR_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        test_default_floor();
        test_floor_zero();
        test_floor_max();
        test_random_stream();
        wait_drained();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[occupancy_cell_bayes_update_unit.f]
rtl/core/ocbu_pkg.sv
rtl/core/ocbu_ram.sv
rtl/core/occupancy_cell_bayes_update_unit.sv
rtl/core/ocbu_checker.sv
tb/tb_occupancy_cell_bayes_update_unit.sv
